// ----- design/pmsq_pkg.sv -----
package pmsq_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int PRIO_LEVELS = 32;
  localparam int MAX_BYTES   = 4096;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int LEN_W  = 12;
  localparam int PRI_W  = 5;
  localparam int AGE_W  = 32;

  localparam logic [4:0]  CFG_SLOTS_RST = 5'd4;
  localparam logic [11:0] CFG_MAXB_RST  = 12'd32;

  localparam logic REG_SLOTS = 1'b0;
  localparam logic REG_MAXB  = 1'b1;

  typedef enum logic {
    MODE_SEND,
    MODE_RECV
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BLOCK,
    ST_TOO_BIG,
    ST_NO_ACCESS,
    ST_BAD_LEN
  } status_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PRI_W-1:0] pri;
    logic [AGE_W-1:0] age;
  } slot_entry_t;

endpackage

// ----- design/pmsq_ram.sv -----
module pmsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/priority_message_slot_queue.sv -----
// send: the result beat is loaded from S_SEND, and input stalls until S_IDLE
// receive: every slot descriptor is read once from the slot ram, one per cycle,
//   then S_LAST and S_DECIDE pass before the result beat is loaded
// a finished result waits in the output register while the next item is taken
// reset clears the slot valid bits, the message count and the age stamp and returns
//   the config registers to their defaults; the slot ram is not cleared
module priority_message_slot_queue
  import pmsq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [11:0] length_i,
  input  logic [4:0]  priority_in_i,
  input  logic        may_write_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [11:0] out_length_o,
  output logic [4:0]  out_priority_o,
  output logic [4:0]  message_count_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_SCAN,
    S_LAST,
    S_DECIDE
  } state_e;

  state_e state_q;

  logic [4:0]  slots_q;
  logic [11:0] maxb_q;

  logic [NUM_SLOTS-1:0] used_q;
  logic [CNT_W-1:0]     held_q;
  logic [AGE_W-1:0]     age_q;

  logic [LEN_W-1:0] op_len_q;
  logic [PRI_W-1:0] op_pri_q;
  logic             op_wr_q;

  logic [SLOT_W-1:0] cnt_q;
  logic              pend_q;
  logic [SLOT_W-1:0] pend_idx_q;
  logic              found_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [LEN_W-1:0]  best_len_q;
  logic [PRI_W-1:0]  best_pri_q;
  logic [AGE_W-1:0]  best_age_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [PRI_W-1:0]  out_pri_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic              cfg_wr;
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic [CNT_W-1:0]  cap;
  logic [LEN_W-1:0]  lim;
  logic [PRI_W-1:0]  send_pri;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  status_e           send_status;
  logic              take;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  slot_entry_t       ram_wdata;
  slot_entry_t       ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_SLOTS: prdata = {27'd0, slots_q};
      REG_MAXB:  prdata = {20'd0, maxb_q};
      default:   prdata = 32'd0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = ((state_q == S_SEND) || (state_q == S_DECIDE)) && out_free;

  assign cap = (CNT_W'(slots_q) > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : CNT_W'(slots_q);

  always_comb begin
    lim = {maxb_q[11:2], 2'b00};
    if (lim > LEN_W'(MAX_BYTES - 4)) begin
      lim = LEN_W'(MAX_BYTES - 4);
    end
  end

  assign send_pri = (op_pri_q > PRI_W'(PRIO_LEVELS - 1)) ? PRI_W'(PRIO_LEVELS - 1) : op_pri_q;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i] && (CNT_W'(i) < cap)) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (!op_wr_q) begin
      send_status = ST_NO_ACCESS;
    end else if (op_len_q > lim) begin
      send_status = ST_TOO_BIG;
    end else if (op_len_q == '0) begin
      send_status = ST_BAD_LEN;
    end else if ((held_q < cap) && free_found) begin
      send_status = ST_OK;
    end else begin
      send_status = ST_BLOCK;
    end
  end

  // best-so-far update for the descriptor that came back from the ram
  assign take = pend_q && used_q[pend_idx_q] &&
                (!found_q || (ram_rdata.pri > best_pri_q) ||
                 ((ram_rdata.pri == best_pri_q) &&
                  ($signed(ram_rdata.age) < $signed(best_age_q))));

  assign ram_we        = (state_q == S_SEND) && out_free && (send_status == ST_OK);
  assign ram_raddr     = cnt_q;
  assign ram_wdata.len = op_len_q;
  assign ram_wdata.pri = send_pri;
  assign ram_wdata.age = age_q;

  pmsq_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slots_q      <= CFG_SLOTS_RST;
      maxb_q       <= CFG_MAXB_RST;
      used_q       <= '0;
      held_q       <= '0;
      age_q        <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_SLOTS: slots_q <= pwdata[4:0];
          REG_MAXB:  maxb_q  <= pwdata[11:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (take) begin
        found_q    <= 1'b1;
        best_idx_q <= pend_idx_q;
        best_len_q <= ram_rdata.len;
        best_pri_q <= ram_rdata.pri;
        best_age_q <= ram_rdata.age;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_len_q  <= length_i;
            op_pri_q  <= priority_in_i;
            op_wr_q   <= may_write_i;
            cnt_q     <= '0;
            pend_q    <= 1'b0;
            found_q   <= 1'b0;
            state_q   <= (mode_i == MODE_SEND) ? S_SEND : S_SCAN;
          end
        end
        S_SEND: begin
          if (out_free) begin
            out_status_q <= send_status;
            if (send_status == ST_OK) begin
              used_q[free_idx] <= 1'b1;
              held_q           <= held_q + 1'b1;
              age_q            <= age_q + 1'b1;
              out_slot_q       <= free_idx;
              out_len_q        <= op_len_q;
              out_pri_q        <= send_pri;
              out_cnt_q        <= held_q + 1'b1;
            end else begin
              out_slot_q <= '0;
              out_len_q  <= '0;
              out_pri_q  <= '0;
              out_cnt_q  <= held_q;
            end
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          pend_q     <= 1'b1;
          pend_idx_q <= cnt_q;
          cnt_q      <= cnt_q + 1'b1;
          if (cnt_q == SLOT_W'(NUM_SLOTS - 1)) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          pend_q  <= 1'b0;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            if (!found_q) begin
              out_status_q <= ST_BLOCK;
              out_slot_q   <= '0;
              out_len_q    <= '0;
              out_pri_q    <= '0;
              out_cnt_q    <= held_q;
            end else if (op_len_q < best_len_q) begin
              out_status_q <= ST_TOO_BIG;
              out_slot_q   <= '0;
              out_len_q    <= '0;
              out_pri_q    <= '0;
              out_cnt_q    <= held_q;
            end else begin
              used_q[best_idx_q] <= 1'b0;
              out_status_q       <= ST_OK;
              out_slot_q         <= best_idx_q;
              out_len_q          <= best_len_q;
              out_pri_q          <= best_pri_q;
              if (held_q != '0) begin
                held_q    <= held_q - 1'b1;
                out_cnt_q <= held_q - 1'b1;
              end else begin
                out_cnt_q <= held_q;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign out_length_o    = out_len_q;
  assign out_priority_o  = out_pri_q;
  assign message_count_o = out_cnt_q;

  a_held_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == CNT_W'($countones(used_q)))
    else $error("message count differs from used slots");

  a_write_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> used_q[$past(free_idx)])
    else $error("written slot not marked used");

  a_write_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !used_q[free_idx])
    else $error("send overwrites a used slot");

  a_ok_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_OK)) |-> (out_length_o != '0))
    else $error("ok beat with zero length");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb
  import pmsq_pkg::*;
;

  typedef struct {
    mode_e       mode;
    logic [11:0] len;
    logic [4:0]  pri;
    logic        may_write;
  } msg_op_t;

  typedef struct {
    status_e     status;
    logic [3:0]  slot;
    logic [11:0] len;
    logic [4:0]  pri;
    logic [4:0]  count;
  } msg_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [11:0] length_i = '0;
  logic [4:0]  priority_in_i = '0;
  logic        may_write_i = 1'b0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  slot_o;
  logic [11:0] out_length_o;
  logic [4:0]  out_priority_o;
  logic [4:0]  message_count_o;

  priority_message_slot_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .length_i       (length_i),
    .priority_in_i  (priority_in_i),
    .may_write_i    (may_write_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .out_length_o   (out_length_o),
    .out_priority_o (out_priority_o),
    .message_count_o(message_count_o)
  );

  always #6 clk_i = ~clk_i;

  // queue model state
  logic [11:0] q_len [NUM_SLOTS];
  logic [4:0]  q_pri [NUM_SLOTS];
  logic [31:0] q_age [NUM_SLOTS];
  logic [4:0]  q_held = '0;
  logic [31:0] q_stamp = '0;
  logic [4:0]  cfg_slots = CFG_SLOTS_RST;
  logic [11:0] cfg_maxb = CFG_MAXB_RST;

  msg_op_t     op_queue[$];
  msg_reply_t  expected_replies[$];
  int          queued_ops = 0;
  int          accepted_ops = 0;
  int          errors = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  logic        in_fire = 1'b0;
  logic        calm = 1'b0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      q_len[i] = '0;
      q_pri[i] = '0;
      q_age[i] = '0;
    end
  end

  function automatic int queue_capacity();
    return (cfg_slots > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_slots);
  endfunction

  function automatic int length_cap();
    int lim;
    lim = int'(cfg_maxb & 12'hFFC);
    return (lim > MAX_BYTES - 4) ? MAX_BYTES - 4 : lim;
  endfunction

  function automatic msg_reply_t predict_reply(input msg_op_t op);
    msg_reply_t r;
    int         cap;
    int         best;
    r.status = ST_BLOCK;
    r.slot   = '0;
    r.len    = '0;
    r.pri    = '0;
    cap      = queue_capacity();
    best     = -1;
    if (op.mode == MODE_SEND) begin
      if (!op.may_write) begin
        r.status = ST_NO_ACCESS;
      end else if (int'(op.len) > length_cap()) begin
        r.status = ST_TOO_BIG;
      end else if (op.len == 0) begin
        r.status = ST_BAD_LEN;
      end else if (int'(q_held) < cap) begin
        for (int i = 0; i < cap && r.status == ST_BLOCK; i++) begin
          if (q_len[i] == 0) begin
            q_len[i] = op.len;
            q_pri[i] = op.pri;
            q_age[i] = q_stamp;
            q_stamp  = q_stamp + 32'd1;
            q_held   = q_held + 5'd1;
            r.status = ST_OK;
            r.slot   = 4'(i);
            r.len    = op.len;
            r.pri    = op.pri;
          end
        end
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (q_len[i] != 0) begin
          if (best < 0 || q_pri[i] > q_pri[best] ||
              (q_pri[i] == q_pri[best] && $signed(q_age[i]) < $signed(q_age[best])))
            best = i;
        end
      end
      if (best < 0) begin
        r.status = ST_BLOCK;
      end else if (op.len < q_len[best]) begin
        r.status = ST_TOO_BIG;
      end else begin
        r.status    = ST_OK;
        r.slot      = 4'(best);
        r.len       = q_len[best];
        r.pri       = q_pri[best];
        q_len[best] = '0;
        if (q_held > 0) q_held = q_held - 5'd1;
      end
    end
    r.count = q_held;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stretches in which no new input gaps or result stalls are begun
  always @(posedge clk_i) begin
    if ($urandom_range(0, 149) == 0) calm <= ~calm;
  end

  // input beat driver
  always @(negedge clk_i) begin
    msg_op_t op;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (op_queue.size() > 0) begin
        op = op_queue.pop_front();
        mode_i        <= op.mode;
        length_i      <= op.len;
        priority_in_i <= op.pri;
        may_write_i   <= op.may_write;
        in_valid_i    <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall driver
  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (calm || r < 70) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      out_stall_i <= 1'b1;
    end
  end

  // input beat monitor and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    msg_op_t op;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        op.mode      = mode_e'(mode_i);
        op.len       = length_i;
        op.pri       = priority_in_i;
        op.may_write = may_write_i;
        expected_replies.push_back(predict_reply(op));
        accepted_ops = accepted_ops + 1;
      end
    end
  end

  // result beat checker
  always @(posedge clk_i) begin
    msg_reply_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_replies.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        e = expected_replies.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status_o);
          errors++;
        end
        if (slot_o !== e.slot) begin
          $error("slot: expected %0d, actual %0d", e.slot, slot_o);
          errors++;
        end
        if (out_length_o !== e.len) begin
          $error("out_length: expected %0d, actual %0d", e.len, out_length_o);
          errors++;
        end
        if (out_priority_o !== e.pri) begin
          $error("out_priority: expected %0d, actual %0d", e.pri, out_priority_o);
          errors++;
        end
        if (message_count_o !== e.count) begin
          $error("message_count: expected %0d, actual %0d", e.count, message_count_o);
          errors++;
        end
      end
    end
  end

  task automatic add_op(input mode_e mode, input int len, input int pri, input logic wr);
    msg_op_t op;
    op.mode      = mode;
    op.len       = 12'(len);
    op.pri       = 5'(pri);
    op.may_write = wr;
    op_queue.push_back(op);
    queued_ops++;
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SLOTS) cfg_slots = val[4:0];
    else cfg_maxb = val[11:0];
  endtask

  task automatic wait_idle();
    while (!(accepted_ops == queued_ops && expected_replies.size() == 0))
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_send();
    int lim;
    int len;
    int pri;
    lim = length_cap();
    len = (lim > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(1, lim)
                                                  : $urandom_range(0, 4095);
    pri = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 31);
    add_op(MODE_SEND, len, pri, $urandom_range(0, 99) < 94);
  endtask

  task automatic random_recv();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 70) len = 4095;
    else if (r < 85) len = $urandom_range(0, 4095);
    else len = $urandom_range(0, length_cap());
    add_op(MODE_RECV, len, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int n, input int send_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < send_pct) random_send();
      else random_recv();
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // capacity 4, limit 32 after reset
    add_op(MODE_RECV, 4095, 31, 1'b0);
    add_op(MODE_SEND, 8, 5, 1'b0);
    add_op(MODE_SEND, 0, 5, 1'b1);
    add_op(MODE_SEND, 33, 5, 1'b1);
    add_op(MODE_SEND, 4095, 31, 1'b1);
    add_op(MODE_SEND, 32, 31, 1'b1);
    add_op(MODE_SEND, 1, 0, 1'b1);
    add_op(MODE_SEND, 4, 31, 1'b1);
    add_op(MODE_SEND, 12, 0, 1'b1);
    add_op(MODE_SEND, 16, 7, 1'b1);
    add_op(MODE_RECV, 0, 0, 1'b1);
    add_op(MODE_RECV, 31, 0, 1'b1);
    add_op(MODE_RECV, 32, 0, 1'b1);
    add_op(MODE_RECV, 4095, 0, 1'b1);
    add_op(MODE_SEND, 20, 16, 1'b1);
    add_op(MODE_RECV, 4095, 0, 1'b0);
    add_op(MODE_RECV, 4095, 0, 1'b1);
    add_op(MODE_RECV, 4095, 0, 1'b1);
    add_op(MODE_RECV, 2730, 21, 1'b1);
    add_op(MODE_RECV, 1365, 10, 1'b0);
    wait_idle();

    reg_write(REG_SLOTS, 32'd16);
    reg_write(REG_MAXB, 32'd4095);
    run_phase(300, 55);
    for (int i = 0; i < 12; i++) random_send();
    wait_idle();

    // capacity lowered while messages are held
    reg_write(REG_SLOTS, 32'd2);
    reg_write(REG_MAXB, 32'd256);
    run_phase(150, 35);

    reg_write(REG_SLOTS, 32'd31);
    reg_write(REG_MAXB, 32'd4092);
    run_phase(300, 50);

    reg_write(REG_SLOTS, 32'd0);
    reg_write(REG_MAXB, 32'd64);
    run_phase(60, 60);

    reg_write(REG_SLOTS, 32'd1);
    reg_write(REG_MAXB, 32'd0);
    run_phase(60, 50);

    reg_write(REG_SLOTS, 32'd8);
    reg_write(REG_MAXB, 32'd7);
    run_phase(200, 50);

    reg_write(REG_SLOTS, 32'd5);
    reg_write(REG_MAXB, 32'd1000);
    run_phase(300, 50);

    reg_write(REG_SLOTS, 32'd16);
    reg_write(REG_MAXB, 32'd128);
    run_phase(400, 52);

    repeat (30) @(negedge clk_i);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
